FILE: rtl/core/fss_pkg.sv
// fss_pkg: shared types and constants of the fair-share slice table.
// No dependencies; imported by the divider, the task table and the top level.
`timescale 1ns / 1ps

package fss_pkg;

  localparam int CMD_W   = 2;
  localparam int TID_W   = 6;
  localparam int GRP_W   = 3;
  localparam int SLICE_W = 9;
  localparam int MEM_W   = 7;
  localparam int BASE_W  = 10;

  localparam logic [CMD_W-1:0] CMD_JOIN      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECOMPUTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST   = 2'd2;

  localparam logic [BASE_W-1:0]  BASE_FACTOR = 10'd5;
  localparam logic [SLICE_W-1:0] TIME_MAX    = 9'd511;
  localparam logic [MEM_W-1:0]   MEMBERS_MAX = 7'd127;

  typedef struct packed {
    logic               in_group;
    logic [GRP_W-1:0]   gid;
    logic [SLICE_W-1:0] remaining;
    logic [SLICE_W-1:0] quota;
  } task_entry_t;

endpackage

FILE: rtl/core/fss_div.sv
// fss_div: restoring divider, one quotient bit per cycle.
// Depends on fss_pkg for the base and member count widths.
`timescale 1ns / 1ps

module fss_div
  import fss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [BASE_W-1:0] dividend,
  input  logic [MEM_W-1:0]  divisor,
  output logic              done,
  output logic [BASE_W-1:0] quotient,
  output logic [MEM_W-1:0]  remainder
);

  localparam int CW = $clog2(BASE_W + 1);

  logic [BASE_W-1:0] dvd_r;
  logic [MEM_W-1:0]  rem_r;
  logic [MEM_W-1:0]  dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [MEM_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, dvd_r[BASE_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(BASE_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[BASE_W-2:0], fits};
      rem_r <= fits ? MEM_W'(trial - {1'b0, dvs_r}) : MEM_W'(trial);
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/fss_table.sv
// fss_table: single-port-read, single-port-write task table memory.
// Depends on fss_pkg for the entry type; valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps

module fss_table
  import fss_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [AW-1:0] rd_addr,
  output task_entry_t rd_data,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  task_entry_t wr_data
);

  task_entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  task_entry_t      rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: rtl/core/fair_share_slice_table.sv
// fair_share_slice_table: top level of the fair-share time-slice table.
// Depends on fss_pkg, fss_div and fss_table.
`timescale 1ns / 1ps

// Channel | Direction | Ports                                        | Handshake
// in      | input     | in_command in_task_id in_group in_is_parent  | in_valid/in_ready
// out     | output    | out_slice out_refilled                       | out_valid/out_ready
//
// One transaction at a time. Join writes its entry in ST_JWR. Request updates its
// entry in ST_QWR, then sweeps the table when it reloads. Recompute finds the
// largest group, runs the serial divider (one quotient bit per cycle) per group,
// then sweeps the table (read then write each entry through the one memory port pair).
// Reset clears control, group counts and all table valid bits.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and only its completion stalls on out_ready.

module fair_share_slice_table
  import fss_pkg::*;
#(
  parameter int TASK_SLOTS = 64,
  parameter int NUM_GROUPS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [TID_W-1:0]   in_task_id,
  input  logic [GRP_W-1:0]   in_group,
  input  logic               in_is_parent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLICE_W-1:0] out_slice,
  output logic               out_refilled
);

  localparam int TW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int GW  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int NW  = $clog2(TASK_SLOTS + 1);
  localparam int PW  = (TW > TID_W) ? TW : TID_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_JWR   = 4'd1;
  localparam logic [3:0] ST_QWR   = 4'd2;
  localparam logic [3:0] ST_RMAX  = 4'd3;
  localparam logic [3:0] ST_RDIV  = 4'd4;
  localparam logic [3:0] ST_RWAIT = 4'd5;
  localparam logic [3:0] ST_SRD   = 4'd6;
  localparam logic [3:0] ST_SWR   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;

  // latched transaction
  logic [TW-1:0]    tid_r;
  logic [GRP_W-1:0] grp_r;

  // group state
  logic [MEM_W-1:0]  members_r [NUM_GROUPS];
  logic [TID_W-1:0]  parent_r  [NUM_GROUPS];
  logic [BASE_W-1:0] quot_r    [NUM_GROUPS];
  logic [MEM_W-1:0]  rmd_r     [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] szero_r;
  logic [GW-1:0]     g_r;
  logic [BASE_W-1:0] base_r;

  // sweep and bookkeeping
  logic [TW-1:0] idx_r;
  logic [NW-1:0] cnt_r;
  logic [NW-1:0] nz_r;
  logic          refill_mode_r;

  // result
  logic [SLICE_W-1:0] res_slice_r;
  logic               res_refill_r;
  logic               out_valid_r;
  logic [SLICE_W-1:0] out_slice_r;
  logic               out_refilled_r;

  // table ports
  logic        tbl_rd_en, tbl_wr_en;
  logic [TW-1:0] tbl_rd_addr, tbl_wr_addr;
  task_entry_t tbl_rd_data, tbl_wr_data;

  // divider
  logic              div_done;
  logic [BASE_W-1:0] div_q;
  logic [MEM_W-1:0]  div_r;

  logic in_fire, out_fire, load_out;
  logic tid_ok, grp_ok;
  logic [MEM_W-1:0] largest;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign tid_ok   = 32'(in_task_id) < TASK_SLOTS;
  assign grp_ok   = 32'(in_group) < NUM_GROUPS;

  fss_table #(.DEPTH(TASK_SLOTS), .AW(TW)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  fss_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_RDIV),
    .dividend  (base_r),
    .divisor   (members_r[g_r]),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // largest group size, scanned over the few group registers
  always_comb begin
    largest = '0;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      if (members_r[k] > largest) largest = members_r[k];
    end
  end

  // per-entry update logic for request and sweep
  task_entry_t        e;
  logic [GW-1:0]      egi;
  logic               egrp_ok;
  logic [BASE_W:0]    qsum;
  logic [SLICE_W-1:0] qnew;
  task_entry_t        sweep_entry;
  logic [SLICE_W-1:0] req_rem;
  logic [NW-1:0]      nz_after;

  always_comb begin
    e       = tbl_rd_data;
    egi     = GW'(e.gid);
    egrp_ok = 32'(e.gid) < NUM_GROUPS;
    qsum    = {1'b0, quot_r[egi]};
    if (PW'(parent_r[egi]) == PW'(idx_r)) qsum = qsum + (BASE_W+1)'(rmd_r[egi]);
    if (!e.in_group)                    qnew = SLICE_W'(1);
    else if (!egrp_ok || szero_r[egi])  qnew = '0;
    else if (qsum > (BASE_W+1)'(TIME_MAX)) qnew = TIME_MAX;
    else                                qnew = SLICE_W'(qsum);
    sweep_entry = e;
    if (refill_mode_r) begin
      sweep_entry.remaining = e.quota;
    end else begin
      sweep_entry.quota     = qnew;
      sweep_entry.remaining = qnew;
    end
    req_rem  = (e.remaining != '0) ? e.remaining - 1'b1 : e.remaining;
    nz_after = (e.remaining == SLICE_W'(1)) ? nz_r - 1'b1 : nz_r;
  end

  // table access
  always_comb begin
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = idx_r;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = tid_r;
    tbl_wr_data = e;
    if (in_fire) begin
      tbl_rd_en   = 1'b1;
      tbl_rd_addr = TW'(in_task_id);
    end else if (state_r == ST_SRD) begin
      tbl_rd_en = 1'b1;
    end
    unique case (state_r)
      ST_JWR: begin
        tbl_wr_en            = 1'b1;
        tbl_wr_data.in_group = 1'b1;
        tbl_wr_data.gid      = grp_r;
      end
      ST_QWR: begin
        tbl_wr_en             = e.in_group;
        tbl_wr_data.remaining = req_rem;
      end
      ST_SWR: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = idx_r;
        tbl_wr_data = sweep_entry;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (1'b1)
            in_command == CMD_JOIN && tid_ok && grp_ok: state_nxt = ST_JWR;
            in_command == CMD_REQUEST && tid_ok:        state_nxt = ST_QWR;
            in_command == CMD_RECOMPUTE:                state_nxt = ST_RMAX;
            default:                                    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_JWR:  state_nxt = ST_DONE;
      ST_QWR:  state_nxt = (e.in_group && nz_after == '0) ? ST_SRD : ST_DONE;
      ST_RMAX: state_nxt = ST_RDIV;
      ST_RDIV: state_nxt = ST_RWAIT;
      ST_RWAIT: begin
        if (div_done) state_nxt = (g_r == GW'(NUM_GROUPS - 1)) ? ST_SRD : ST_RDIV;
      end
      ST_SRD:  state_nxt = ST_SWR;
      ST_SWR:  state_nxt = (idx_r == TW'(TASK_SLOTS - 1)) ? ST_DONE : ST_SRD;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic sweep_hit;
  assign sweep_hit = e.in_group && sweep_entry.remaining != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nz_r        <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
        members_r[k] <= '0;
        parent_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // count joins and record the parent at acceptance
      if (in_fire && in_command == CMD_JOIN && tid_ok && grp_ok) begin
        for (int k = 0; k < NUM_GROUPS; k++) begin
          if (GRP_W'(k) == in_group) begin
            if (members_r[k] < MEMBERS_MAX) members_r[k] <= members_r[k] + 1'b1;
            if (in_is_parent) parent_r[k] <= in_task_id;
          end
        end
      end
      if (state_r == ST_JWR && !e.in_group && e.remaining != '0) nz_r <= nz_r + 1'b1;
      if (state_r == ST_QWR && e.in_group) nz_r <= nz_after;
      if (state_r == ST_SWR && idx_r == TW'(TASK_SLOTS - 1)) begin
        nz_r <= cnt_r + NW'(sweep_hit);
      end
      if (load_out)      out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tid_r        <= TW'(in_task_id);
      grp_r        <= in_group;
      res_slice_r  <= '0;
      res_refill_r <= 1'b0;
    end
    if (state_r == ST_QWR) begin
      res_slice_r   <= e.in_group ? e.remaining : SLICE_W'(1);
      res_refill_r  <= e.in_group && nz_after == '0;
      refill_mode_r <= 1'b1;
      idx_r         <= '0;
      cnt_r         <= '0;
    end
    if (state_r == ST_RMAX) begin
      base_r <= BASE_W'(largest) * BASE_FACTOR;
      g_r    <= '0;
    end
    if (state_r == ST_RWAIT && div_done) begin
      quot_r[g_r]  <= div_q;
      rmd_r[g_r]   <= div_r;
      szero_r[g_r] <= members_r[g_r] == '0;
      g_r          <= g_r + 1'b1;
      // hold the sweep setup for the table pass that follows the last group
      refill_mode_r <= 1'b0;
      idx_r         <= '0;
      cnt_r         <= '0;
    end
    if (state_r == ST_SWR) begin
      idx_r <= idx_r + 1'b1;
      cnt_r <= cnt_r + NW'(sweep_hit);
    end
    if (load_out) begin
      out_slice_r    <= res_slice_r;
      out_refilled_r <= res_refill_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_slice    = out_slice_r;
  assign out_refilled = out_refilled_r;

  // a result whose slice is above one leaves time behind, so it never reloads
  a_slice_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slice > SLICE_W'(1) |-> !out_refilled)
    else $error("refill reported with time left");

  a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nz_r) <= TASK_SLOTS)
    else $error("nonzero task count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second transaction taken while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_RWAIT)
    else $error("divider finished outside its wait state");

endmodule

FILE: verif/tb_fair_share_slice_table.sv
// tb_fair_share_slice_table: self-checking bench for the fair-share slice table.
// Depends on fss_pkg and fair_share_slice_table; a scoreboard class predicts results.
`timescale 1ns / 1ps

module tb_fair_share_slice_table;
  import fss_pkg::*;

  localparam int SLOTS  = 64;
  localparam int GROUPS = 5;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  // Scoreboard: own copy of the slice table state plus a queue of predicted results.
  class slice_scoreboard;
    bit             grouped [SLOTS];
    bit [2:0]       grp_of  [SLOTS];
    bit [8:0]       left_t  [SLOTS];
    bit [8:0]       quota_t [SLOTS];
    bit [6:0]       members [GROUPS];
    bit [5:0]       parent  [GROUPS];
    bit [9:0]       pending_slice [$];
    int             mismatches;
    int             checked;
    int             refills;

    function void clear();
      foreach (grouped[i]) begin
        grouped[i] = 0; grp_of[i] = 0; left_t[i] = 0; quota_t[i] = 0;
      end
      foreach (members[g]) begin
        members[g] = 0; parent[g] = 0;
      end
      mismatches = 0; checked = 0; refills = 0;
    endfunction

    // Apply one accepted transaction and queue the result it must produce.
    function void note_input(bit [1:0] cmd, bit [5:0] tid, bit [2:0] grp, bit par);
      int unsigned largest, base, sz, q, total;
      bit [8:0] sl;
      bit rf;
      sl = 0; rf = 0;
      if (cmd == CMD_JOIN) begin
        if (grp < GROUPS) begin
          grouped[tid] = 1;
          grp_of[tid] = grp;
          if (members[grp] < MEMBERS_MAX) members[grp]++;
          if (par) parent[grp] = tid;
        end
      end else if (cmd == CMD_RECOMPUTE) begin
        largest = 0;
        foreach (members[g]) if (members[g] > largest) largest = members[g];
        base = largest * 5;
        foreach (grouped[i]) begin
          q = 1;
          if (grouped[i]) begin
            sz = (grp_of[i] < GROUPS) ? members[grp_of[i]] : 0;
            q = 0;
            if (sz != 0) begin
              q = base / sz;
              if (parent[grp_of[i]] == i) q += base % sz;
            end
          end
          quota_t[i] = (q > 511) ? 9'd511 : q[8:0];
          left_t[i] = quota_t[i];
        end
      end else if (cmd == CMD_REQUEST) begin
        if (!grouped[tid]) sl = 1;
        else begin
          sl = left_t[tid];
          if (left_t[tid] > 0) left_t[tid]--;
          total = 0;
          foreach (grouped[i]) if (grouped[i]) total += left_t[i];
          if (total == 0) begin
            rf = 1;
            foreach (left_t[i]) left_t[i] = quota_t[i];
          end
        end
      end
      pending_slice.push_back({rf, sl});
    endfunction

    function void check_result(bit [8:0] sl, bit rf);
      bit [9:0] exp_r;
      if (pending_slice.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result slice=%0d refilled=%0d", sl, rf);
        return;
      end
      exp_r = pending_slice.pop_front();
      checked++;
      if (rf) refills++;
      if (exp_r[8:0] !== sl || exp_r[9] !== rf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected slice=%0d refilled=%0d, got slice=%0d refilled=%0d",
                   checked, exp_r[8:0], exp_r[9], sl, rf);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_is_parent;
  logic [CMD_W-1:0] in_command;
  logic [TID_W-1:0] in_task_id;
  logic [GRP_W-1:0] in_group;
  logic out_valid, out_ready, out_refilled;
  logic [SLICE_W-1:0] out_slice;

  slice_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int cycles;
  int sent;

  fair_share_slice_table i_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run at a generous cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fair_share_slice_table: mismatch");
      $finish;
    end
  end

  // Sample on the rising edge: note accepted inputs, check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_command, in_task_id, in_group, in_is_parent);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_slice, out_refilled);
  end

  // Receiver: drop ready at random on the falling edge per the current stall rate.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one transaction: random idle gap, then hold valid until accepted.
  // Valid stays high after acceptance so a back-to-back transaction can follow directly.
  task automatic send_txn(bit [1:0] cmd, bit [5:0] tid, bit [2:0] grp, bit par);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_command <= cmd; in_task_id <= tid; in_group <= grp;
    in_is_parent <= par;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Hold the sender until every predicted result has drained.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_slice.size() != 0) @(negedge clk);
  endtask

  // Random traffic biased toward grouped tasks and requests so refills happen often.
  task automatic random_txn();
    int r;
    bit [1:0] cmd;
    r = $urandom_range(99);
    if (r < 20) cmd = CMD_JOIN;
    else if (r < 27) cmd = CMD_RECOMPUTE;
    else if (r < 97) cmd = CMD_REQUEST;
    else cmd = CMD_UNUSED;
    send_txn(cmd, 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11)),
             3'(($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(4)),
             1'($urandom_range(1)));
  endtask

  initial begin
    sb = new();
    sb.clear();
    sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 0; in_valid = 0; in_command = '0; in_task_id = '0; in_group = '0;
    in_is_parent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: requests before any recompute, extremes, bad groups, unused command.
    send_txn(CMD_REQUEST, 6'd0, 3'd0, 1'b0);
    send_txn(CMD_JOIN, 6'd0, 3'd0, 1'b1);
    send_txn(CMD_REQUEST, 6'd0, 3'd0, 1'b0);
    send_txn(CMD_JOIN, 6'd63, 3'd4, 1'b1);
    send_txn(CMD_JOIN, 6'd5, 3'd7, 1'b1);
    send_txn(CMD_JOIN, 6'd6, 3'd5, 1'b0);
    send_txn(CMD_JOIN, 6'd1, 3'd0, 1'b0);
    send_txn(CMD_JOIN, 6'd2, 3'd0, 1'b0);
    send_txn(CMD_JOIN, 6'd2, 3'd1, 1'b1);
    send_txn(CMD_JOIN, 6'd3, 3'd2, 1'b1);
    send_txn(CMD_JOIN, 6'd3, 3'd3, 1'b0);
    send_txn(CMD_UNUSED, 6'd42, 3'd6, 1'b1);
    send_txn(CMD_RECOMPUTE, 6'd0, 3'd0, 1'b0);
    send_txn(CMD_REQUEST, 6'd63, 3'd4, 1'b0);
    send_txn(CMD_REQUEST, 6'd63, 3'd4, 1'b0);
    send_txn(CMD_REQUEST, 6'd63, 3'd4, 1'b0);
    send_txn(CMD_REQUEST, 6'd40, 3'd0, 1'b1);
    send_txn(CMD_REQUEST, 6'd3, 3'd0, 1'b0);
    send_txn(CMD_REQUEST, 6'd0, 3'd0, 1'b0);
    drain();

    // Saturate group 4 past 127 members to hit the count limit and quota clamp.
    for (int k = 0; k < 130; k++) send_txn(CMD_JOIN, 6'd63, 3'd4, 1'b0);
    send_txn(CMD_JOIN, 6'd10, 3'd1, 1'b1);
    send_txn(CMD_RECOMPUTE, 6'd0, 3'd0, 1'b0);
    send_txn(CMD_REQUEST, 6'd10, 3'd1, 1'b0);
    send_txn(CMD_REQUEST, 6'd63, 3'd4, 1'b0);

    // Random phases with different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int k = 0; k < 140; k++) random_txn();
      drain();
    end

    // Fresh mix after a full drain, all stalls off, to finish.
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int k = 0; k < 40; k++) random_txn();

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results, %0d with a table reload.",
             sent, sb.checked, sb.refills);
    if (sb.mismatches == 0 && sb.pending_slice.size() == 0) begin
      $display("fair_share_slice_table: match");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("fair_share_slice_table: mismatch");
    end
    $finish;
  end

endmodule
